// File: rtl/spcc_pkg.sv
package spcc_pkg;

    // Field and register widths
    localparam int SPEED_W   = 16;
    localparam int DT_W      = 20;
    localparam int ERR_W     = 17;
    localparam int GAIN_W    = 32;
    localparam int BOUND_W   = 47;
    localparam int ACC_W     = 48;
    localparam int MAXCUR_W  = 21;
    localparam int CUR_W     = 22;
    localparam int RAW_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 47;

    // Shared multiplier operand widths
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 24;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    // Wide intermediate widths
    localparam int SUM_W     = 49;
    localparam int CMD_W     = 50;
    localparam int ITERM_W   = 41;

    // Elapsed time substitution and output limits
    localparam logic [DT_W-1:0]  DT_MAX_US      = 20'd200000;
    localparam logic [DT_W-1:0]  DT_FALLBACK_US = 20'd10000;
    localparam logic [16:0]      RAW_LIMIT      = 17'd32767;
    localparam logic [ITERM_W-1:0] ITERM_CAP    = 41'h100_0000_0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MEASURED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_BOUND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CURRENT     = 3'd4;

    // Program addresses
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_ED = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ACC    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_PROP   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_HI     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_PH     = 4'd5;
    localparam logic [STEP_W-1:0] STEP_SUM    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_CLAMP  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_OUT    = 4'd8;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ERR_DT,
        MUL_KP_ERR,
        MUL_KI_HI,
        MUL_KI_LO
    } t_mul_sel;

    // Datapath register update
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LATCH,
        OP_ACC_ADD,
        OP_PROP_ABS,
        OP_PH,
        OP_SUM,
        OP_CLAMP,
        OP_OUT
    } t_op;

    // Sequencing of the step counter
    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_WAIT_OUT
    } t_jmp;

    typedef struct packed {
        t_mul_sel mul;
        t_op      op;
        t_jmp     jmp;
    } t_uword;

    // Control program, one word per step
    function automatic t_uword uc_rom(input logic [STEP_W-1:0] addr);
        t_uword w;
        w = '{mul: MUL_NONE, op: OP_NOP, jmp: JMP_NEXT};
        unique case (addr)
            STEP_IDLE:   w = '{mul: MUL_NONE,   op: OP_LATCH,    jmp: JMP_WAIT_IN};
            STEP_MUL_ED: w = '{mul: MUL_ERR_DT, op: OP_NOP,      jmp: JMP_NEXT};
            STEP_ACC:    w = '{mul: MUL_KP_ERR, op: OP_ACC_ADD,  jmp: JMP_NEXT};
            STEP_PROP:   w = '{mul: MUL_NONE,   op: OP_PROP_ABS, jmp: JMP_NEXT};
            STEP_HI:     w = '{mul: MUL_KI_HI,  op: OP_NOP,      jmp: JMP_NEXT};
            STEP_PH:     w = '{mul: MUL_KI_LO,  op: OP_PH,       jmp: JMP_NEXT};
            STEP_SUM:    w = '{mul: MUL_NONE,   op: OP_SUM,      jmp: JMP_NEXT};
            STEP_CLAMP:  w = '{mul: MUL_NONE,   op: OP_CLAMP,    jmp: JMP_NEXT};
            STEP_OUT:    w = '{mul: MUL_NONE,   op: OP_OUT,      jmp: JMP_WAIT_OUT};
            default:     w = '{mul: MUL_NONE,   op: OP_NOP,      jmp: JMP_WAIT_OUT};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/speed_pi_current_command_top.sv
// Speed PI controller giving a current command. Each item (speed reference,
// measured speed, elapsed time) is taken by one idle step and then passes
// through eight program steps of a small control store, the last of which
// loads the result into the output register once that register is free. The
// steps hold four products (error*time, kp*error and the two halves of
// ki*|integral|) that pass one after another through a single registered 32x24
// multiplier, followed by a sum, a clamp-and-round and an output step. Items
// are processed one at a time; the next item is taken as soon as the previous
// result has gone into the output register, so a waiting result does not hold
// the block unless a second one is ready before the first is taken. The
// integral (48-bit, rpm-us) is kept between items and cleared by reset.
// Configuration is written through a plain write port; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module speed_pi_current_command_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Configuration write port
    input  logic                                    i_cfg_we,
    input  logic [spcc_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [spcc_pkg::CFG_DAT_W-1:0]          i_cfg_data,
    // Input channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [spcc_pkg::SPEED_W-1:0]     i_speed_ref,
    input  logic signed [spcc_pkg::SPEED_W-1:0]     i_speed_meas,
    input  logic [spcc_pkg::DT_W-1:0]               i_elapsed_us,
    // Output channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [spcc_pkg::CUR_W-1:0]       o_current_cmd,
    output logic signed [spcc_pkg::RAW_W-1:0]       o_raw_cmd
);

    // Configuration registers
    logic                                 r_invert;
    logic [spcc_pkg::GAIN_W-1:0]          r_prop_gain;
    logic [spcc_pkg::GAIN_W-1:0]          r_integ_gain;
    logic [spcc_pkg::BOUND_W-1:0]         r_integral_bound;
    logic [spcc_pkg::MAXCUR_W-1:0]        r_max_current;

    // Sequencer
    logic [spcc_pkg::STEP_W-1:0]          r_step;
    logic [spcc_pkg::STEP_W-1:0]          n_step;
    spcc_pkg::t_uword                     uw;
    logic                                 in_accept;
    logic                                 out_free;
    logic                                 out_load;

    // Datapath registers
    logic [spcc_pkg::ERR_W-1:0]           r_err_mag;
    logic                                 r_err_neg;
    logic [spcc_pkg::DT_W-1:0]            r_dt;
    logic [spcc_pkg::MUL_P_W-1:0]         r_prod;
    logic signed [spcc_pkg::ACC_W-1:0]    r_acc;
    logic signed [spcc_pkg::ACC_W-1:0]    n_acc;
    logic [spcc_pkg::BOUND_W-1:0]         r_acc_mag;
    logic                                 r_acc_neg;
    logic signed [spcc_pkg::CMD_W-1:0]    r_p;
    logic                                 r_ph_big;
    logic [31:0]                          r_ph_lo;
    logic signed [spcc_pkg::CMD_W-1:0]    r_c;
    logic [spcc_pkg::MAXCUR_W-1:0]        r_cmag;
    logic                                 r_neg;

    // Output register
    logic                                 r_out_valid;
    logic signed [spcc_pkg::CUR_W-1:0]    r_current_cmd;
    logic signed [spcc_pkg::RAW_W-1:0]    r_raw_cmd;

    // Combinational results
    logic [spcc_pkg::ERR_W-1:0]           err_mag;
    logic                                 err_neg;
    logic [spcc_pkg::DT_W-1:0]            dt_fix;
    logic [spcc_pkg::MUL_A_W-1:0]         mul_a;
    logic [spcc_pkg::MUL_B_W-1:0]         mul_b;
    logic [spcc_pkg::BOUND_W-1:0]         acc_mag;
    logic signed [spcc_pkg::CMD_W-1:0]    p_val;
    logic signed [spcc_pkg::CMD_W-1:0]    c_val;
    logic [spcc_pkg::MAXCUR_W-1:0]        cmag;
    logic                                 c_neg;
    logic signed [spcc_pkg::CUR_W-1:0]    cur_val;
    logic signed [spcc_pkg::RAW_W-1:0]    raw_val;

    assign uw        = spcc_pkg::uc_rom(r_step);
    assign in_accept = i_in_valid && (uw.jmp == spcc_pkg::JMP_WAIT_IN);
    assign out_free  = !(r_out_valid && i_out_stall);
    assign out_load  = (uw.op == spcc_pkg::OP_OUT) && out_free;

    assign o_in_stall    = (uw.jmp != spcc_pkg::JMP_WAIT_IN);
    assign o_out_valid   = r_out_valid;
    assign o_current_cmd = r_current_cmd;
    assign o_raw_cmd     = r_raw_cmd;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert         <= 1'b0;
            r_prop_gain      <= '0;
            r_integ_gain     <= '0;
            r_integral_bound <= '0;
            r_max_current    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                spcc_pkg::CFG_INVERT_MEASURED: r_invert         <= i_cfg_data[0];
                spcc_pkg::CFG_PROP_GAIN:       r_prop_gain      <= i_cfg_data[31:0];
                spcc_pkg::CFG_INTEG_GAIN:      r_integ_gain     <= i_cfg_data[31:0];
                spcc_pkg::CFG_INTEGRAL_BOUND:  r_integral_bound <= i_cfg_data;
                spcc_pkg::CFG_MAX_CURRENT:     r_max_current    <= i_cfg_data[20:0];
                default: ;
            endcase
        end
    end

    // Next step: wait for an item, advance, or wait for the output slot
    always_comb begin
        n_step = r_step;
        unique case (uw.jmp)
            spcc_pkg::JMP_WAIT_IN:  n_step = in_accept ? r_step + 4'd1 : r_step;
            spcc_pkg::JMP_NEXT:     n_step = r_step + 4'd1;
            spcc_pkg::JMP_WAIT_OUT: n_step = out_free ? spcc_pkg::STEP_IDLE : r_step;
            default:                n_step = spcc_pkg::STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= spcc_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Speed error and elapsed time of an incoming item
    always_comb begin
        logic signed [spcc_pkg::ERR_W-1:0] ref17;
        logic signed [spcc_pkg::ERR_W-1:0] meas17;
        logic signed [spcc_pkg::ERR_W:0]   diff;
        logic [spcc_pkg::ERR_W-1:0]        err;
        ref17   = {i_speed_ref[15], i_speed_ref};
        meas17  = {i_speed_meas[15], i_speed_meas};
        if (r_invert) begin
            meas17 = -meas17;
        end
        diff    = {ref17[16], ref17} - {meas17[16], meas17};
        err     = diff[16:0];
        err_neg = err[16];
        err_mag = err_neg ? (17'd0 - err) : err;
        if ((i_elapsed_us == '0) || (i_elapsed_us > spcc_pkg::DT_MAX_US)) begin
            dt_fix = spcc_pkg::DT_FALLBACK_US;
        end else begin
            dt_fix = i_elapsed_us;
        end
    end

    // Select multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (uw.mul)
            spcc_pkg::MUL_NONE: begin
                mul_a = '0;
                mul_b = '0;
            end
            spcc_pkg::MUL_ERR_DT: begin
                mul_a = {15'd0, r_err_mag};
                mul_b = {4'd0, r_dt};
            end
            spcc_pkg::MUL_KP_ERR: begin
                mul_a = r_prop_gain;
                mul_b = {7'd0, r_err_mag};
            end
            spcc_pkg::MUL_KI_HI: begin
                mul_a = r_integ_gain;
                mul_b = {1'b0, r_acc_mag[46:24]};
            end
            spcc_pkg::MUL_KI_LO: begin
                mul_a = r_integ_gain;
                mul_b = r_acc_mag[23:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Shared multiplier, registered product
    always_ff @(posedge i_clk) begin
        r_prod <= spcc_pkg::MUL_P_W'(mul_a) * spcc_pkg::MUL_P_W'(mul_b);
    end

    // Integral update and clamp to the bound, or clear when the integral gain is zero
    always_comb begin
        logic signed [spcc_pkg::SUM_W-1:0] delta;
        logic signed [spcc_pkg::SUM_W-1:0] sum;
        logic signed [spcc_pkg::SUM_W-1:0] bnd;
        logic signed [spcc_pkg::SUM_W-1:0] nbnd;
        delta = {13'd0, r_prod[35:0]};
        if (r_err_neg) begin
            delta = -delta;
        end
        sum  = {r_acc[47], r_acc} + delta;
        bnd  = {2'b00, r_integral_bound};
        nbnd = -bnd;
        if (r_integ_gain == '0) begin
            n_acc = '0;
        end else if (sum > bnd) begin
            n_acc = bnd[47:0];
        end else if (sum < nbnd) begin
            n_acc = nbnd[47:0];
        end else begin
            n_acc = sum[47:0];
        end
    end

    // Proportional term and integral magnitude
    always_comb begin
        logic signed [spcc_pkg::ACC_W-1:0] acc_abs;
        p_val   = {1'b0, r_prod[48:0]};
        if (r_err_neg) begin
            p_val = -p_val;
        end
        acc_abs = r_acc[47] ? -r_acc : r_acc;
        acc_mag = acc_abs[46:0];
    end

    // Integral term with saturation, then the unclamped command
    always_comb begin
        logic [spcc_pkg::ITERM_W-1:0] t;
        logic [spcc_pkg::ITERM_W-1:0] im;
        t = {1'b0, r_ph_lo, 8'd0} + {1'b0, r_prod[55:16]};
        if (r_ph_big || (t > spcc_pkg::ITERM_CAP)) begin
            im = spcc_pkg::ITERM_CAP;
        end else begin
            im = t;
        end
        if (r_acc_neg) begin
            c_val = r_p - $signed({9'd0, im});
        end else begin
            c_val = r_p + $signed({9'd0, im});
        end
    end

    // Clamp to the current limit and round to Q5.16
    always_comb begin
        logic signed [spcc_pkg::CMD_W-1:0] lim;
        logic signed [spcc_pkg::CMD_W-1:0] nlim;
        logic signed [spcc_pkg::CMD_W-1:0] cl;
        logic signed [spcc_pkg::CMD_W-1:0] cabs;
        logic [29:0]                       rnd;
        lim  = {21'd0, r_max_current, 8'd0};
        nlim = -lim;
        if (r_c > lim) begin
            cl = lim;
        end else if (r_c < nlim) begin
            cl = nlim;
        end else begin
            cl = r_c;
        end
        c_neg = cl[49];
        cabs  = c_neg ? -cl : cl;
        rnd   = {1'b0, cabs[28:0]} + 30'd128;
        cmag  = rnd[28:8];
    end

    // Signed command and driver word
    always_comb begin
        logic [35:0] scaled;
        logic [16:0] rmag;
        logic [15:0] rmag16;
        scaled  = {r_cmag, 15'd0} - {15'd0, r_cmag};
        scaled  = scaled + 36'h4_0000;
        rmag    = scaled[35:19];
        if (rmag > spcc_pkg::RAW_LIMIT) begin
            rmag = spcc_pkg::RAW_LIMIT;
        end
        rmag16  = rmag[15:0];
        cur_val = r_neg ? -$signed({1'b0, r_cmag}) : $signed({1'b0, r_cmag});
        raw_val = r_neg ? -$signed(rmag16) : $signed(rmag16);
    end

    // Datapath registers, loaded under the control word
    always_ff @(posedge i_clk) begin
        if (in_accept && (uw.op == spcc_pkg::OP_LATCH)) begin
            r_err_mag <= err_mag;
            r_err_neg <= err_neg;
            r_dt      <= dt_fix;
        end
        if (uw.op == spcc_pkg::OP_PROP_ABS) begin
            r_p       <= p_val;
            r_acc_mag <= acc_mag;
            r_acc_neg <= r_acc[47];
        end
        if (uw.op == spcc_pkg::OP_PH) begin
            r_ph_big <= |r_prod[55:32];
            r_ph_lo  <= r_prod[31:0];
        end
        if (uw.op == spcc_pkg::OP_SUM) begin
            r_c <= c_val;
        end
        if (uw.op == spcc_pkg::OP_CLAMP) begin
            r_cmag <= cmag;
            r_neg  <= c_neg;
        end
        if (out_load) begin
            r_current_cmd <= cur_val;
            r_raw_cmd     <= raw_val;
        end
    end

    // Hold the integral between items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (uw.op == spcc_pkg::OP_ACC_ADD) begin
            r_acc <= n_acc;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (o_in_stall && (r_step == spcc_pkg::STEP_MUL_ED)))
        else $error("sequencer did not start after taking an item");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= spcc_pkg::STEP_OUT)
        else $error("step counter outside the program");

    a_integral_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((uw.op == spcc_pkg::OP_ACC_ADD) && (r_integ_gain == '0)) |=> (r_acc == '0))
        else $error("integral not cleared with zero integral gain");

    a_sign_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_raw_cmd != '0)) |-> (o_raw_cmd[15] == o_current_cmd[21]))
        else $error("driver word and command disagree in sign");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import spcc_pkg::*;

    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 128;

    typedef struct packed {
        logic signed [CUR_W-1:0] cur;
        logic signed [RAW_W-1:0] raw;
    } t_cmd;

    typedef struct packed {
        logic                inv;
        logic [GAIN_W-1:0]   kp;
        logic [GAIN_W-1:0]   ki;
        logic [BOUND_W-1:0]  bound;
        logic [MAXCUR_W-1:0] max_cur;
    } t_gains;

    typedef struct packed {
        logic [2:0]                gains_id;
        logic signed [SPEED_W-1:0] spd_ref;
        logic signed [SPEED_W-1:0] spd_meas;
        logic [DT_W-1:0]           dt;
        logic                      typed;
        t_cmd                      cmd;
    } t_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_idx = '0;
    logic [CFG_DAT_W-1:0]        i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic signed [SPEED_W-1:0]   i_speed_ref = '0;
    logic signed [SPEED_W-1:0]   i_speed_meas = '0;
    logic [DT_W-1:0]             i_elapsed_us = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic signed [CUR_W-1:0]     o_current_cmd;
    logic signed [RAW_W-1:0]     o_raw_cmd;

    // Controller model state, mirrors the block after reset
    t_gains  live_gains = '0;
    longint  speed_integral = 0;
    t_cmd    pending_cmds[$];
    t_row    dir_rows[$];
    t_gains  gain_sets[6];
    int      n_items = 0;
    int      n_directed = 0;
    int      n_cmds = 0;
    int      n_errors = 0;
    int      n_settings = 0;
    int      burst_left = 0;

    speed_pi_current_command_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_speed_ref   (i_speed_ref),
        .i_speed_meas  (i_speed_meas),
        .i_elapsed_us  (i_elapsed_us),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_current_cmd (o_current_cmd),
        .o_raw_cmd     (o_raw_cmd)
    );

    always #2 i_clk = ~i_clk;

    // Work out the command for one item and advance the integral
    function automatic t_cmd next_current_cmd(input logic signed [SPEED_W-1:0] spd_ref,
                                              input logic signed [SPEED_W-1:0] spd_meas,
                                              input logic [DT_W-1:0] dt_in);
        longint          meas_v, err, dt_v, bound, kp_v, prop, total, lim;
        longint unsigned mag, iterm, cmag, rmag;
        logic [79:0]     iprod;
        logic            neg;
        t_cmd            res;
        // Substitute the fallback for a missing or stale time step
        if (dt_in == '0 || dt_in > DT_MAX_US)
            dt_v = longint'(DT_FALLBACK_US);
        else
            dt_v = longint'(dt_in);
        meas_v = longint'(spd_meas);
        if (live_gains.inv)
            meas_v = -meas_v;
        err = longint'(spd_ref) - meas_v;

        // Integrate, then hold within the bound or drop when ki is zero
        speed_integral = speed_integral + err * dt_v;
        bound = longint'(live_gains.bound);
        if (live_gains.ki == '0)
            speed_integral = 0;
        else if (speed_integral > bound)
            speed_integral = bound;
        else if (speed_integral < -bound)
            speed_integral = -bound;

        // Proportional and integral terms in Q24 amps
        kp_v = longint'(live_gains.kp);
        prop = kp_v * err;
        mag = (speed_integral < 0) ? -speed_integral : speed_integral;
        iprod = 80'(live_gains.ki) * 80'(mag);
        iprod = iprod >> 16;
        iterm = (iprod > 80'h100_0000_0000) ? 64'h100_0000_0000 : iprod[63:0];
        total = (speed_integral < 0) ? prop - longint'(iterm) : prop + longint'(iterm);

        // Clamp to the current limit, round to Q5.16 and scale the driver word
        lim = longint'({live_gains.max_cur, 8'h00});
        if (total > lim)
            total = lim;
        if (total < -lim)
            total = -lim;
        neg = total < 0;
        cmag = neg ? -total : total;
        cmag = (cmag + 128) >> 8;
        rmag = (cmag * RAW_LIMIT + (64'd1 << 18)) >> 19;
        if (rmag > RAW_LIMIT)
            rmag = RAW_LIMIT;
        res.cur = CUR_W'(neg ? -cmag : cmag);
        res.raw = RAW_W'(neg ? -rmag : rmag);
        return res;
    endfunction

    function automatic t_gains make_gains(input logic inv, input logic [GAIN_W-1:0] kp,
                                          input logic [GAIN_W-1:0] ki,
                                          input logic [BOUND_W-1:0] bound,
                                          input logic [MAXCUR_W-1:0] max_cur);
        t_gains g;
        g.inv = inv;
        g.kp = kp;
        g.ki = ki;
        g.bound = bound;
        g.max_cur = max_cur;
        return g;
    endfunction

    // Gain with a spread of magnitudes, extremes included
    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic t_gains rand_gains();
        t_gains g;
        g.inv = 1'($urandom_range(0, 1));
        g.kp = rand_gain();
        g.ki = rand_gain();
        case ($urandom_range(0, 5))
            0:       g.bound = '0;
            1:       g.bound = '1;
            default: g.bound = BOUND_W'({$urandom, $urandom} >> $urandom_range(17, 63));
        endcase
        case ($urandom_range(0, 5))
            0:       g.max_cur = '0;
            1:       g.max_cur = '1;
            2:       g.max_cur = 21'h10_0000;
            default: g.max_cur = MAXCUR_W'($urandom >> $urandom_range(11, 31));
        endcase
        return g;
    endfunction

    task automatic add_row(input int gid, input int spd_ref, input int spd_meas, input int dt,
                           input bit typed, input int cur, input int raw);
        t_row r;
        r.gains_id = gid[2:0];
        r.spd_ref = spd_ref[SPEED_W-1:0];
        r.spd_meas = spd_meas[SPEED_W-1:0];
        r.dt = dt[DT_W-1:0];
        r.typed = typed;
        r.cmd.cur = cur[CUR_W-1:0];
        r.cmd.raw = raw[RAW_W-1:0];
        dir_rows.push_back(r);
    endtask

    task automatic note_mismatch(input string what, input longint want, input longint got);
        n_errors++;
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    // Offer one item, with a random gap at the start of each burst
    task automatic push_item(input logic signed [SPEED_W-1:0] spd_ref,
                             input logic signed [SPEED_W-1:0] spd_meas,
                             input logic [DT_W-1:0] dt, input bit typed, input t_cmd typed_cmd);
        t_cmd predicted;
        int   gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_speed_ref = spd_ref;
        i_speed_meas = spd_meas;
        i_elapsed_us = dt;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predicted = next_current_cmd(spd_ref, spd_meas, dt);
        pending_cmds.push_back(typed ? typed_cmd : predicted);
        n_items++;
        @(negedge i_clk);
    endtask

    // Wait until every command is out and the block has settled
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_cmds.size() != 0)
            @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic apply_gains(input t_gains g);
        drain();
        write_reg(CFG_INVERT_MEASURED, CFG_DAT_W'(g.inv));
        write_reg(CFG_PROP_GAIN, CFG_DAT_W'(g.kp));
        write_reg(CFG_INTEG_GAIN, CFG_DAT_W'(g.ki));
        write_reg(CFG_INTEGRAL_BOUND, CFG_DAT_W'(g.bound));
        write_reg(CFG_MAX_CURRENT, CFG_DAT_W'(g.max_cur));
        live_gains = g;
        n_settings++;
    endtask

    // Check each command taken from the block against the oldest prediction
    always @(posedge i_clk) begin : check_cmd
        t_cmd want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cmds.size() == 0) begin
                n_errors++;
                $display("%0t ns: unexpected command, expected none, got current %0d raw %0d",
                         $time, o_current_cmd, o_raw_cmd);
            end else begin
                want = pending_cmds.pop_front();
                n_cmds++;
                if (o_current_cmd !== want.cur)
                    note_mismatch("current_cmd", longint'(want.cur), longint'(o_current_cmd));
                if (o_raw_cmd !== want.raw)
                    note_mismatch("raw_cmd", longint'(want.raw), longint'(o_raw_cmd));
            end
        end
    end

    // Receiver back-pressure: segments of free flow, random, periodic and bursty stalls
    initial begin
        int mode, seg, k, hold;
        hold = 0;
        forever begin
            seg = $urandom_range(50, 400);
            mode = $urandom_range(0, 3);
            for (k = 0; k < seg; k++) begin
                @(negedge i_clk);
                case (mode)
                    0: i_out_stall = 1'b0;
                    1: i_out_stall = ($urandom_range(0, 2) == 0);
                    2: i_out_stall = (k % 4) != 0;
                    default: begin
                        if (hold > 0) begin
                            i_out_stall = 1'b1;
                            hold--;
                        end else begin
                            i_out_stall = 1'b0;
                            if ($urandom_range(0, 7) == 0)
                                hold = $urandom_range(1, 15);
                        end
                    end
                endcase
            end
        end
    end

    // Stimulus: directed table, then random gain settings with random items
    initial begin
        int   cur_gid, p, n;
        logic signed [SPEED_W-1:0] r, m;
        logic [DT_W-1:0] dt;

        gain_sets[0] = '0;
        gain_sets[1] = make_gains(1'b0, '1, '0, '0, '1);
        gain_sets[2] = make_gains(1'b1, 32'h0100_0000, '0, '0, 21'h10_0000);
        gain_sets[3] = make_gains(1'b0, '0, 32'h0100_0000, 47'd1000000, '1);
        gain_sets[4] = make_gains(1'b0, '0, '1, '1, '1);
        gain_sets[5] = make_gains(1'b0, '0, '1, 47'd5, '1);

        // All gains zero after reset: every command is zero
        add_row(0,  32767, -32768,       0, 1, 0, 0);
        add_row(0, -32768,  32767, 1048575, 1, 0, 0);
        add_row(0,      0,      0,       1, 1, 0, 0);
        // Full proportional gain saturates at the widest current limit
        add_row(1,  32767, -32768,     100, 1,  2097151,  32767);
        add_row(1, -32768,  32767,     100, 1, -2097151, -32767);
        add_row(1,      0,      0,       5, 1,        0,      0);
        // Inverted measurement, including the most negative error
        add_row(2, -32768, -32768,  200000, 1, -1048576, -32767);
        add_row(2,      7,     -7,      10, 1,        0,      0);
        add_row(2,    100,      3,      10, 0,        0,      0);
        add_row(2,  32767,  32767,  524287, 0,        0,      0);
        // Bad elapsed times fall back; integral runs into its bound
        add_row(3,     10,      0,       0, 0, 0, 0);
        add_row(3,     10,      0,  200001, 0, 0, 0);
        add_row(3,     10,      0,  200000, 0, 0, 0);
        add_row(3,     10,      0,       1, 0, 0, 0);
        add_row(3,    -10,      0, 1048575, 0, 0, 0);
        add_row(3, -32768,  32767,  200000, 0, 0, 0);
        // Huge integral term saturates, command pinned at the limit
        add_row(4,  32767, -32768,  200000, 1, 2097151, 32767);
        add_row(4,  32767, -32768,  200000, 1, 2097151, 32767);
        add_row(4, -32768,  32767,       1, 0, 0, 0);
        // Lowered bound clamps the kept integral on the next item
        add_row(5,      0,      0,       1, 0, 0, 0);
        add_row(5,    -50,     50,    1000, 0, 0, 0);

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        cur_gid = 0;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].gains_id != cur_gid) begin
                cur_gid = dir_rows[k].gains_id;
                apply_gains(gain_sets[cur_gid]);
            end
            push_item(dir_rows[k].spd_ref, dir_rows[k].spd_meas, dir_rows[k].dt,
                      dir_rows[k].typed, dir_rows[k].cmd);
        end
        n_directed = n_items;

        for (p = 0; p < N_PHASES; p++) begin
            apply_gains(rand_gains());
            for (n = 0; n < PHASE_ITEMS; n++) begin
                r = SPEED_W'($urandom);
                case ($urandom_range(0, 5))
                    0, 1: m = SPEED_W'($urandom);
                    2, 3: m = SPEED_W'(int'(r) + int'($urandom_range(0, 512)) - 256);
                    4: begin
                        r = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                        m = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                    end
                    default: m = r;
                endcase
                case ($urandom_range(0, 9))
                    0:       dt = '0;
                    1:       dt = DT_W'($urandom_range(200001, 1048575));
                    2:       dt = $urandom_range(0, 1) ? DT_MAX_US : 20'd1;
                    3:       dt = DT_W'($urandom_range(1, 100));
                    default: dt = DT_W'($urandom_range(1, 200000));
                endcase
                push_item(r, m, dt, 1'b0, '0);
            end
        end
        drain();

        $display("Sent %0d items (%0d from the directed table) over %0d gain settings,",
                 n_items, n_directed, n_settings);
        $display("checked %0d commands under varied sender gaps and receiver stalls.", n_cmds);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog on the whole run
    initial begin
        #2_000_000;
        $display("Timeout with %0d commands outstanding", pending_cmds.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: speed_pi_current_command_top.f
rtl/spcc_pkg.sv
rtl/speed_pi_current_command_top.sv
tb/tb.sv
